// ----- src/rrafm_pkg.sv -----
// rrafm_pkg: shared types, codes and helpers for the round-robin converter fault monitor
// no dependencies; compiled first

`default_nettype none

package rrafm_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int SLOT_W          = 3;
    localparam int OC_CNT_W        = 7;
    localparam int MODE_W          = 2;
    localparam int GRADE_W         = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int DIRT_WINDOW_DEF = 20;

    // reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] OC_THR_RST     = 16'd11252;
    localparam logic [OC_CNT_W-1:0] OC_WINDOW_RST  = 7'd100;
    localparam logic [OC_CNT_W-1:0] OC_LIMIT_RST   = 7'd15;
    localparam logic [SAMPLE_W-1:0] BT_THR_RST     = 16'h2300;
    localparam logic [SAMPLE_W-1:0] VDIRTY_THR_RST = 16'h3500;
    localparam logic [SAMPLE_W-1:0] DIRTY_THR_RST  = 16'h5100;

    // dirt grading hit limits
    localparam logic [7:0] VERY_DIRTY_LIMIT = 8'd3;
    localparam logic [7:0] DIRTY_LIMIT      = 8'd6;

    typedef enum logic [SLOT_W-1:0] {
        SLOT_BRUSH_I = 3'd0,
        SLOT_PUMP_I  = 3'd1,
        SLOT_BTYPE   = 3'd2,
        SLOT_WATER   = 3'd3,
        SLOT_IR      = 3'd4
    } t_slot;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OC_THR     = 3'd0,
        CFG_OC_WINDOW  = 3'd1,
        CFG_OC_LIMIT   = 3'd2,
        CFG_BT_THR     = 3'd3,
        CFG_VDIRTY_THR = 3'd4,
        CFG_DIRTY_THR  = 3'd5,
        CFG_WORK_MODE  = 3'd6
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_OTHER       = 2'd0,
        MODE_INTELLIGENT = 2'd1,
        MODE_CARPET      = 2'd2,
        MODE_SPARE       = 2'd3
    } t_mode;

    typedef enum logic [GRADE_W-1:0] {
        GRADE_CLEAN      = 2'd0,
        GRADE_DIRTY      = 2'd1,
        GRADE_VERY_DIRTY = 2'd2
    } t_grade;

    // mean of the middle two of four: min/max pair network, then 17-bit sum
    function automatic logic [SAMPLE_W-1:0] trim_mean(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c,
        input logic [SAMPLE_W-1:0] d
    );
        logic [SAMPLE_W-1:0] lo_ab;
        logic [SAMPLE_W-1:0] hi_ab;
        logic [SAMPLE_W-1:0] lo_cd;
        logic [SAMPLE_W-1:0] hi_cd;
        logic [SAMPLE_W-1:0] mid_lo;
        logic [SAMPLE_W-1:0] mid_hi;
        logic [SAMPLE_W:0]   sum;
        lo_ab  = (a < b) ? a : b;
        hi_ab  = (a < b) ? b : a;
        lo_cd  = (c < d) ? c : d;
        hi_cd  = (c < d) ? d : c;
        mid_lo = (lo_ab > lo_cd) ? lo_ab : lo_cd;
        mid_hi = (hi_ab < hi_cd) ? hi_ab : hi_cd;
        sum    = {1'b0, mid_lo} + {1'b0, mid_hi};
        return sum[SAMPLE_W:1];
    endfunction

endpackage

`default_nettype wire

// ----- src/rrafm_in_if.sv -----
// rrafm_in_if: input item channel (valid/ready plus sample payload)
// depends on rrafm_pkg

`default_nettype none

interface rrafm_in_if;
    logic                             valid;
    logic                             ready;
    logic [rrafm_pkg::SAMPLE_W-1:0]   sample;
    logic                             ir_transmit_on;

    modport source (output valid, output sample, output ir_transmit_on, input ready);
    modport sink   (input valid, input sample, input ir_transmit_on, output ready);
endinterface

`default_nettype wire

// ----- src/rrafm_out_if.sv -----
// rrafm_out_if: result item channel (valid/ready plus status payload)
// depends on rrafm_pkg

`default_nettype none

interface rrafm_out_if;
    logic                             valid;
    logic                             ready;
    logic [rrafm_pkg::SLOT_W-1:0]     next_slot;
    logic                             brush_overcurrent;
    logic                             pump_overcurrent;
    logic                             brush_kind_err;
    logic [rrafm_pkg::GRADE_W-1:0]    dirt_level;
    logic [rrafm_pkg::SAMPLE_W-1:0]   water_average;

    modport source (
        output valid, output next_slot, output brush_overcurrent, output pump_overcurrent,
        output brush_kind_err, output dirt_level, output water_average, input ready
    );
    modport sink (
        input valid, input next_slot, input brush_overcurrent, input pump_overcurrent,
        input brush_kind_err, input dirt_level, input water_average, output ready
    );
endinterface

`default_nettype wire

// ----- src/round_robin_adc_fault_monitor_top.sv -----
// round_robin_adc_fault_monitor_top: five-slot converter fault monitor, single module
// depends on rrafm_pkg, rrafm_in_if, rrafm_out_if

// Each accepted item is one converter sample for the slot that the previous result named
// (0 brush current, 1 pump current, 2 brush type, 3 water, 4 infrared; the rotation starts
// at slot 0 after reset). The block sustains one item per clock while results drain: an
// item is captured in an input register, and once the result register is free or being
// drained, one short logic pass updates the slot's detector and loads the result register.
// The input register refills while a result waits, so a stalled consumer costs at most the
// two stages of buffering before ready drops. Current slots judge overcurrent over a
// programmable window, brush type and water keep a trimmed mean of four samples, and the
// infrared slot grades dirt over DIRT_WINDOW samples taken with the emitter on.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data and must
// only be changed while no item is in flight.

`default_nettype none

module round_robin_adc_fault_monitor_top #(
    parameter int DIRT_WINDOW = rrafm_pkg::DIRT_WINDOW_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [rrafm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [rrafm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rrafm_in_if.sink                             i_item,
    rrafm_out_if.source                          o_result
);
    import rrafm_pkg::*;

    // dirt counters only need to reach the window length
    localparam int IR_W = $clog2(DIRT_WINDOW + 1);

    // configuration registers
    logic [SAMPLE_W-1:0] r_oc_thr;
    logic [OC_CNT_W-1:0] r_oc_window;
    logic [OC_CNT_W-1:0] r_oc_limit;
    logic [SAMPLE_W-1:0] r_bt_thr;
    logic [SAMPLE_W-1:0] r_vdirty_thr;
    logic [SAMPLE_W-1:0] r_dirty_thr;
    t_mode               r_mode;

    // input stage
    logic                r_in_vld;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_in_ir_on;

    // detector state
    t_slot               r_slot,      n_slot;
    logic [OC_CNT_W-1:0] r_bw_cnt,    n_bw_cnt;
    logic [OC_CNT_W-1:0] r_bh_cnt,    n_bh_cnt;
    logic [OC_CNT_W-1:0] r_pw_cnt,    n_pw_cnt;
    logic [OC_CNT_W-1:0] r_ph_cnt,    n_ph_cnt;
    logic [SAMPLE_W-1:0] r_bt_buf [3];
    logic [1:0]          r_bt_fill,   n_bt_fill;
    logic [SAMPLE_W-1:0] r_bt_mean,   n_bt_mean;
    logic [SAMPLE_W-1:0] r_wt_buf [3];
    logic [1:0]          r_wt_fill,   n_wt_fill;
    logic [SAMPLE_W-1:0] r_wt_mean,   n_wt_mean;
    logic [IR_W-1:0]     r_ir_cnt,    n_ir_cnt;
    logic [IR_W-1:0]     r_vd_hits,   n_vd_hits;
    logic [IR_W-1:0]     r_d_hits,    n_d_hits;
    logic                r_brush_oc,  n_brush_oc;
    logic                r_pump_oc,   n_pump_oc;
    logic                r_bt_err,    n_bt_err;
    t_grade              r_grade,     n_grade;

    // result register
    logic                r_out_vld;

    logic w_adv;
    logic w_fire;
    logic w_in_acc;

    // result stage moves when its register is empty or being drained
    assign w_adv    = !r_out_vld || o_result.ready;
    assign w_fire   = r_in_vld && w_adv;
    assign w_in_acc = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_vld || w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc_thr     <= OC_THR_RST;
            r_oc_window  <= OC_WINDOW_RST;
            r_oc_limit   <= OC_LIMIT_RST;
            r_bt_thr     <= BT_THR_RST;
            r_vdirty_thr <= VDIRTY_THR_RST;
            r_dirty_thr  <= DIRTY_THR_RST;
            r_mode       <= MODE_OTHER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OC_THR:     r_oc_thr     <= i_cfg_data;
                CFG_OC_WINDOW:  r_oc_window  <= i_cfg_data[OC_CNT_W-1:0];
                CFG_OC_LIMIT:   r_oc_limit   <= i_cfg_data[OC_CNT_W-1:0];
                CFG_BT_THR:     r_bt_thr     <= i_cfg_data;
                CFG_VDIRTY_THR: r_vdirty_thr <= i_cfg_data;
                CFG_DIRTY_THR:  r_dirty_thr  <= i_cfg_data;
                CFG_WORK_MODE:  r_mode       <= t_mode'(i_cfg_data[MODE_W-1:0]);
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_sample <= i_item.sample;
            r_in_ir_on  <= i_item.ir_transmit_on;
        end
    end

    // one pass of detector logic for the current slot
    always_comb begin
        logic oc_hit;
        logic [OC_CNT_W-1:0] win_inc;
        logic [OC_CNT_W-1:0] hit_inc;
        logic [SAMPLE_W-1:0] bt_mean_now;

        n_slot     = SLOT_BRUSH_I;
        n_bw_cnt   = r_bw_cnt;
        n_bh_cnt   = r_bh_cnt;
        n_pw_cnt   = r_pw_cnt;
        n_ph_cnt   = r_ph_cnt;
        n_bt_fill  = r_bt_fill;
        n_bt_mean  = r_bt_mean;
        n_wt_fill  = r_wt_fill;
        n_wt_mean  = r_wt_mean;
        n_ir_cnt   = r_ir_cnt;
        n_vd_hits  = r_vd_hits;
        n_d_hits   = r_d_hits;
        n_brush_oc = r_brush_oc;
        n_pump_oc  = r_pump_oc;
        n_bt_err   = r_bt_err;
        n_grade    = r_grade;

        oc_hit      = (r_in_sample >= r_oc_thr);
        win_inc     = '0;
        hit_inc     = '0;
        bt_mean_now = r_bt_mean;

        unique case (r_slot)
            SLOT_BRUSH_I: begin
                win_inc = r_bw_cnt + OC_CNT_W'(1);
                hit_inc = oc_hit ? r_bh_cnt + OC_CNT_W'(1) : r_bh_cnt;
                // window end: judge, then restart both counters
                if (win_inc >= r_oc_window) begin
                    n_brush_oc = (hit_inc >= r_oc_limit);
                    n_bw_cnt   = '0;
                    n_bh_cnt   = '0;
                end else begin
                    n_bw_cnt   = win_inc;
                    n_bh_cnt   = hit_inc;
                end
                n_slot = SLOT_PUMP_I;
            end
            SLOT_PUMP_I: begin
                win_inc = r_pw_cnt + OC_CNT_W'(1);
                hit_inc = oc_hit ? r_ph_cnt + OC_CNT_W'(1) : r_ph_cnt;
                if (win_inc >= r_oc_window) begin
                    n_pump_oc = (hit_inc >= r_oc_limit);
                    n_pw_cnt  = '0;
                    n_ph_cnt  = '0;
                end else begin
                    n_pw_cnt  = win_inc;
                    n_ph_cnt  = hit_inc;
                end
                n_slot = SLOT_BTYPE;
            end
            SLOT_BTYPE: begin
                // the fourth sample completes the buffer and goes straight into the mean
                if (r_bt_fill == 2'd3) begin
                    bt_mean_now = trim_mean(r_bt_buf[0], r_bt_buf[1], r_bt_buf[2],
                                            r_in_sample);
                end
                n_bt_mean = bt_mean_now;
                n_bt_fill = r_bt_fill + 2'd1;
                if (bt_mean_now < r_bt_thr) begin
                    n_bt_err = 1'b1;
                end else if (r_mode == MODE_INTELLIGENT || r_mode == MODE_CARPET) begin
                    n_bt_err = 1'b0;
                end
                n_slot = SLOT_WATER;
            end
            SLOT_WATER: begin
                if (r_wt_fill == 2'd3) begin
                    n_wt_mean = trim_mean(r_wt_buf[0], r_wt_buf[1], r_wt_buf[2],
                                          r_in_sample);
                end
                n_wt_fill = r_wt_fill + 2'd1;
                n_slot    = SLOT_IR;
            end
            SLOT_IR: begin
                // dirt counters hold while the emitter is off
                if (r_in_ir_on) begin
                    n_ir_cnt = r_ir_cnt + IR_W'(1);
                    if (r_in_sample < r_vdirty_thr) begin
                        n_vd_hits = r_vd_hits + IR_W'(1);
                    end else if (r_in_sample < r_dirty_thr) begin
                        n_d_hits = r_d_hits + IR_W'(1);
                    end
                    if (n_ir_cnt >= IR_W'(DIRT_WINDOW)) begin
                        if (8'(n_vd_hits) >= VERY_DIRTY_LIMIT) begin
                            n_grade = GRADE_VERY_DIRTY;
                        end else if (8'(n_d_hits) >= DIRTY_LIMIT) begin
                            n_grade = GRADE_DIRTY;
                        end else begin
                            n_grade = GRADE_CLEAN;
                        end
                        n_ir_cnt  = '0;
                        n_vd_hits = '0;
                        n_d_hits  = '0;
                    end
                end
                n_slot = SLOT_BRUSH_I;
            end
            default: begin
                // unused slot codes fall back to the start of the rotation
                n_slot = SLOT_BRUSH_I;
            end
        endcase
    end

    // detector state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= SLOT_BRUSH_I;
            r_bw_cnt   <= '0;
            r_bh_cnt   <= '0;
            r_pw_cnt   <= '0;
            r_ph_cnt   <= '0;
            r_bt_fill  <= '0;
            r_bt_mean  <= '0;
            r_wt_fill  <= '0;
            r_wt_mean  <= '0;
            r_ir_cnt   <= '0;
            r_vd_hits  <= '0;
            r_d_hits   <= '0;
            r_brush_oc <= 1'b0;
            r_pump_oc  <= 1'b0;
            r_bt_err   <= 1'b0;
            r_grade    <= GRADE_CLEAN;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_slot     <= n_slot;
                r_bw_cnt   <= n_bw_cnt;
                r_bh_cnt   <= n_bh_cnt;
                r_pw_cnt   <= n_pw_cnt;
                r_ph_cnt   <= n_ph_cnt;
                r_bt_fill  <= n_bt_fill;
                r_bt_mean  <= n_bt_mean;
                r_wt_fill  <= n_wt_fill;
                r_wt_mean  <= n_wt_mean;
                r_ir_cnt   <= n_ir_cnt;
                r_vd_hits  <= n_vd_hits;
                r_d_hits   <= n_d_hits;
                r_brush_oc <= n_brush_oc;
                r_pump_oc  <= n_pump_oc;
                r_bt_err   <= n_bt_err;
                r_grade    <= n_grade;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // four-sample buffers, only the first three entries are stored
    always_ff @(posedge i_clk) begin
        if (w_fire && r_slot == SLOT_BTYPE && r_bt_fill != 2'd3) begin
            r_bt_buf[r_bt_fill] <= r_in_sample;
        end
        if (w_fire && r_slot == SLOT_WATER && r_wt_fill != 2'd3) begin
            r_wt_buf[r_wt_fill] <= r_in_sample;
        end
    end

    // result payload is the live state, which changes only when a new result loads
    assign o_result.valid             = r_out_vld;
    assign o_result.next_slot         = r_slot;
    assign o_result.brush_overcurrent = r_brush_oc;
    assign o_result.pump_overcurrent  = r_pump_oc;
    assign o_result.brush_kind_err    = r_bt_err;
    assign o_result.dirt_level        = r_grade;
    assign o_result.water_average     = r_wt_mean;

    // every processed item leaves a result behind
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_vld)
        else $error("processed item produced no result");

    // rotation advances by exactly one slot per processed item
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> ((($past(r_slot) == SLOT_IR) && (r_slot == SLOT_BRUSH_I)) ||
                    (($past(r_slot) != SLOT_IR) &&
                     (r_slot == t_slot'($past(r_slot) + SLOT_W'(1))))))
        else $error("slot rotation skipped or repeated");

    // a result may not be overwritten while it is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_result.ready) |-> !w_fire)
        else $error("pending result overwritten");

    // dirt hits never outnumber counted infrared samples
    a_dirt_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_vd_hits} + {1'b0, r_d_hits}) <= {1'b0, r_ir_cnt})
        else $error("dirt hit counters exceed window count");

    // slot state only moves when an item is processed
    a_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_slot))
        else $error("slot changed without an item");

endmodule

`default_nettype wire
